// ===== rtl/rwcp_pkg.sv =====
// rwcp_pkg: shared types and constants for the RIFF WAVE chunk parser.
// Used by every module in rtl/ except rwcp_divider. No dependencies.
`default_nettype none
package rwcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] EV_FORMAT = 2'd0;
  localparam logic [1:0] EV_DATA   = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NOT_RIFF  = 4'd1;
  localparam logic [3:0] ERR_NOT_WAVE  = 4'd2;
  localparam logic [3:0] ERR_SECOND    = 4'd3;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd4;
  localparam logic [3:0] ERR_NO_FMT    = 4'd5;
  localparam logic [3:0] ERR_TRUNC     = 4'd6;
  localparam logic [3:0] ERR_ZERO      = 4'd7;
  localparam logic [3:0] ERR_SHORT_FMT = 4'd8;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV_A,
    S_DIV_B,
    S_SUM,
    S_EMIT0,
    S_EMIT1
  } state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  error_code;
    logic [31:0] rate_sps;
    logic [15:0] channel_count;
    logic [13:0] sample_bytes;
    logic [31:0] chunk_offset;
    logic [31:0] sample_total;
    logic        run_last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic step;       // byte accepted this edge
    logic div_start;  // launch a divide
    logic div_second; // divide is quotient / channels
    logic div_store;  // keep final quotient
    logic sum_add;    // fold count into total
    logic ev_sel;     // which pending event is shown
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] ev_cnt;
    logic       need_div;
    logic       div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/rwcp_divider.sv =====
// rwcp_divider: restoring divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle. Depends on nothing.
`default_nettype none
module rwcp_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic [31:0]      quot_o,
  output logic             done_o
);

  logic [31:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_q[15:0], quot_q[31]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d  = rem_sub;
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/rwcp_datapath.sv =====
// rwcp_datapath: parse state, per-byte update, pending events and result word.
// Depends on rwcp_pkg and rwcp_divider.
`default_nettype none
module rwcp_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rwcp_pkg::in_word_t in_word_i,
  input  wire rwcp_pkg::cmd_t    cmd_i,
  output rwcp_pkg::sts_t         sts_o,
  output rwcp_pkg::out_word_t    out_word_o
);

  rwcp_pkg::phase_e phase_q, phase_d;
  logic [31:0] idx_q, idx_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic        seen_q, seen_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] cnt_q, cnt_d;
  logic [1:0]  k0_q, k0_d, k1_q, k1_d;
  logic [3:0]  e0_q, e0_d, e1_q, e1_d;
  logic [1:0]  n_q, n_d;
  logic        nd_q, nd_d;

  logic [7:0]  b;
  logic [31:0] bw;
  logic [4:0]  sh;
  logic        has_m, has_t;
  logic [1:0]  m_kind, t_kind;
  logic [3:0]  m_err, t_err;
  logic [32:0] padded;
  logic [32:0] idx_inc;
  logic [31:0] len_base;
  logic [13:0] sb;
  logic [32:0] sum_w;
  logic [31:0] cnt_fix;
  logic [31:0] div_q;
  logic        div_done;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;

  assign b   = in_word_i.data_byte;
  assign bw  = {24'd0, b};
  assign sh  = {idx_q[1:0], 3'd0};
  assign sb  = 14'((({1'b0, bits_q}) + 17'd7) >> 3);
  assign padded  = ({1'b0, len_q} + 33'd1) & ~33'd1;
  assign idx_inc = {1'b0, idx_q} + 33'd1;
  assign len_base = (idx_q == 32'd0) ? 32'd0 : len_q;

  // per-byte update
  always_comb begin
    phase_d = phase_q;
    idx_d = idx_q; remain_d = remain_q; pos_d = pos_q; tag_d = tag_q;
    len_d = len_q; seen_d = seen_q; ftag_d = ftag_q; ch_d = ch_q;
    rate_d = rate_q; bits_d = bits_q;
    has_m = 1'b0; m_kind = rwcp_pkg::EV_ERROR; m_err = rwcp_pkg::ERR_NONE;
    has_t = 1'b0; t_kind = rwcp_pkg::EV_DONE; t_err = rwcp_pkg::ERR_NONE;
    nd_d = 1'b0;
    if (!(phase_q inside {rwcp_pkg::PH_DONE, rwcp_pkg::PH_ERROR})) begin
      pos_d = pos_q + 32'd1;
      idx_d = idx_q + 32'd1;
      case (phase_q)
        rwcp_pkg::PH_HEADER: begin
          tag_d = {b, tag_q[31:8]};
          if (idx_q inside {[32'd4:32'd7]}) len_d = len_q | (bw << sh);
          if (idx_q == 32'd3 && tag_d != rwcp_pkg::TAG_RIFF) begin
            has_m = 1'b1; m_err = rwcp_pkg::ERR_NOT_RIFF;
            phase_d = rwcp_pkg::PH_ERROR;
          end else if (idx_q == 32'd7) begin
            remain_d = (len_d < 32'd4) ? 32'd0 : len_d - 32'd4;
          end else if (idx_q == 32'd11) begin
            if (tag_d != rwcp_pkg::TAG_WAVE) begin
              has_m = 1'b1; m_err = rwcp_pkg::ERR_NOT_WAVE;
              phase_d = rwcp_pkg::PH_ERROR;
            end else if (remain_q == 32'd0) begin
              has_t = 1'b1; phase_d = rwcp_pkg::PH_DONE;
            end else begin
              phase_d = rwcp_pkg::PH_CHUNK; idx_d = '0;
            end
          end
        end
        rwcp_pkg::PH_CHUNK: begin
          len_d = len_base;
          if (idx_q < 32'd4) tag_d = {b, tag_q[31:8]};
          else len_d = len_base | (bw << sh);
          remain_d = remain_q - 32'd1;
          if (idx_q == 32'd7) begin
            idx_d = '0;
            phase_d = (len_d == 32'd0) ? rwcp_pkg::PH_CHUNK : rwcp_pkg::PH_SKIP;
            if (tag_q == rwcp_pkg::TAG_FMT) begin
              if (seen_q) begin
                has_m = 1'b1; m_err = rwcp_pkg::ERR_SECOND;
                phase_d = rwcp_pkg::PH_ERROR;
              end else if (len_d < 32'd16) begin
                has_m = 1'b1; m_err = rwcp_pkg::ERR_SHORT_FMT;
                phase_d = rwcp_pkg::PH_ERROR;
              end else begin
                seen_d = 1'b1; phase_d = rwcp_pkg::PH_FMT;
              end
            end else if (tag_q == rwcp_pkg::TAG_DATA) begin
              if (!seen_q) begin
                has_m = 1'b1; m_err = rwcp_pkg::ERR_NO_FMT;
                phase_d = rwcp_pkg::PH_ERROR;
              end else begin
                has_m = 1'b1; m_kind = rwcp_pkg::EV_DATA; nd_d = 1'b1;
              end
            end
            if (phase_d != rwcp_pkg::PH_ERROR && remain_d == 32'd0) begin
              has_t = 1'b1; phase_d = rwcp_pkg::PH_DONE;
            end
          end else if (remain_d == 32'd0) begin
            has_t = 1'b1; phase_d = rwcp_pkg::PH_DONE;
          end
        end
        default: begin
          if (phase_q == rwcp_pkg::PH_FMT && idx_q < 32'd16) begin
            if (idx_q < 32'd2) ftag_d = ftag_q | (16'(b) << {idx_q[0], 3'd0});
            else if (idx_q < 32'd4) ch_d = ch_q | (16'(b) << {idx_q[0], 3'd0});
            else if (idx_q < 32'd8) rate_d = rate_q | (bw << sh);
            else if (idx_q >= 32'd14) bits_d = bits_q | (16'(b) << {idx_q[0], 3'd0});
          end
          remain_d = remain_q - 32'd1;
          if (phase_q == rwcp_pkg::PH_FMT && idx_q == 32'd15) begin
            has_m = 1'b1;
            if (ftag_d != 16'd1) begin
              m_err = rwcp_pkg::ERR_NOT_PCM; phase_d = rwcp_pkg::PH_ERROR;
            end else if (ch_d == 16'd0 || bits_d == 16'd0) begin
              m_err = rwcp_pkg::ERR_ZERO; phase_d = rwcp_pkg::PH_ERROR;
            end else begin
              m_kind = rwcp_pkg::EV_FORMAT;
            end
          end
          if (phase_d != rwcp_pkg::PH_ERROR) begin
            if (remain_d == 32'd0) begin
              has_t = 1'b1; phase_d = rwcp_pkg::PH_DONE;
            end else if (idx_inc == padded) begin
              phase_d = rwcp_pkg::PH_CHUNK; idx_d = '0;
            end
          end
        end
      endcase
      if (in_word_i.last_byte &&
          !(phase_d inside {rwcp_pkg::PH_DONE, rwcp_pkg::PH_ERROR})) begin
        has_t = 1'b1; t_kind = rwcp_pkg::EV_ERROR; t_err = rwcp_pkg::ERR_TRUNC;
        phase_d = rwcp_pkg::PH_ERROR;
      end
    end
    // pack pending events in order
    if (has_m) begin
      k0_d = m_kind; e0_d = m_err; k1_d = t_kind; e1_d = t_err;
      n_d = has_t ? 2'd2 : 2'd1;
    end else begin
      k0_d = t_kind; e0_d = t_err; k1_d = t_kind; e1_d = t_err;
      n_d = {1'b0, has_t};
    end
  end

  assign div_dividend = cmd_i.div_second ? div_q : len_q;
  assign div_divisor  = cmd_i.div_second ? ch_q : {2'b00, sb};

  rwcp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_q),
    .done_o     (div_done)
  );

  // zero divisors give a zero count
  assign cnt_fix = (sb == 14'd0 || ch_q == 16'd0) ? 32'd0 : cnt_q;
  assign sum_w   = {1'b0, sum_q} + {1'b0, cnt_fix};

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (cmd_i.div_store) cnt_d = div_q;
    if (cmd_i.sum_add) begin
      cnt_d = cnt_fix;
      sum_d = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rwcp_pkg::PH_HEADER;
      idx_q <= '0; remain_q <= '0; pos_q <= '0; tag_q <= '0; len_q <= '0;
      seen_q <= 1'b0; ftag_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= '0;
      sum_q <= '0; cnt_q <= '0;
      k0_q <= '0; k1_q <= '0; e0_q <= '0; e1_q <= '0; n_q <= '0; nd_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        phase_q <= phase_d; idx_q <= idx_d; remain_q <= remain_d;
        pos_q <= pos_d; tag_q <= tag_d; len_q <= len_d; seen_q <= seen_d;
        ftag_q <= ftag_d; ch_q <= ch_d; rate_q <= rate_d; bits_q <= bits_d;
        k0_q <= k0_d; k1_q <= k1_d; e0_q <= e0_d; e1_q <= e1_d;
        n_q <= n_d; nd_q <= nd_d;
      end
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  assign sts_o.ev_cnt   = n_q;
  assign sts_o.need_div = nd_q;
  assign sts_o.div_done = div_done;

  logic [1:0] kind;
  logic       ok;
  always_comb begin
    kind = cmd_i.ev_sel ? k1_q : k0_q;
    ok   = kind != rwcp_pkg::EV_ERROR;
    out_word_o.event_kind    = kind;
    out_word_o.error_code    = cmd_i.ev_sel ? e1_q : e0_q;
    out_word_o.rate_sps      = ok ? rate_q : 32'd0;
    out_word_o.channel_count = ok ? ch_q : 16'd0;
    out_word_o.sample_bytes  = ok ? sb : 14'd0;
    out_word_o.chunk_offset  = (kind == rwcp_pkg::EV_DATA) ? pos_q : 32'd0;
    out_word_o.sample_total  = (kind == rwcp_pkg::EV_DATA) ? cnt_q :
                               (kind == rwcp_pkg::EV_DONE) ? sum_q : 32'd0;
    out_word_o.run_last      = cmd_i.ev_sel || (n_q == 2'd1);
  end

endmodule
`default_nettype wire

// ===== rtl/rwcp_ctrl.sv =====
// rwcp_ctrl: sequencer for byte intake, divide, total update and emission.
// Depends on rwcp_pkg.
`default_nettype none
module rwcp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire rwcp_pkg::sts_t sts_i,
  output rwcp_pkg::cmd_t      cmd_o
);

  rwcp_pkg::state_e state_q, state_d;
  logic in_acc, out_acc;

  assign in_stall_o  = state_q != rwcp_pkg::S_IDLE;
  assign out_valid_o = state_q == rwcp_pkg::S_EMIT0 || state_q == rwcp_pkg::S_EMIT1;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rwcp_pkg::S_IDLE:     if (in_acc) state_d = rwcp_pkg::S_DISPATCH;
      rwcp_pkg::S_DISPATCH: begin
        if (sts_i.need_div) state_d = rwcp_pkg::S_DIV_A;
        else if (sts_i.ev_cnt != 2'd0) state_d = rwcp_pkg::S_EMIT0;
        else state_d = rwcp_pkg::S_IDLE;
      end
      rwcp_pkg::S_DIV_A:    if (sts_i.div_done) state_d = rwcp_pkg::S_DIV_B;
      rwcp_pkg::S_DIV_B:    if (sts_i.div_done) state_d = rwcp_pkg::S_SUM;
      rwcp_pkg::S_SUM:      state_d = rwcp_pkg::S_EMIT0;
      rwcp_pkg::S_EMIT0: begin
        if (out_acc) state_d = (sts_i.ev_cnt == 2'd2) ? rwcp_pkg::S_EMIT1 : rwcp_pkg::S_IDLE;
      end
      rwcp_pkg::S_EMIT1:    if (out_acc) state_d = rwcp_pkg::S_IDLE;
      default:              state_d = rwcp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.step   = in_acc;
    cmd_o.ev_sel = state_q == rwcp_pkg::S_EMIT1;
    case (state_q)
      rwcp_pkg::S_DISPATCH: cmd_o.div_start = sts_i.need_div;
      rwcp_pkg::S_DIV_A: begin
        cmd_o.div_start  = sts_i.div_done;
        cmd_o.div_second = 1'b1;
      end
      rwcp_pkg::S_DIV_B:    cmd_o.div_store = sts_i.div_done;
      rwcp_pkg::S_SUM:      cmd_o.sum_add = 1'b1;
      default:              cmd_o.step = in_acc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rwcp_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  a_acc_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == rwcp_pkg::S_DISPATCH)
    else $error("byte accept not followed by dispatch");

  a_sum_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rwcp_pkg::S_SUM |-> sts_i.ev_cnt != 2'd0)
    else $error("total update without a pending event");

  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sts_i.ev_cnt != 2'd0)
    else $error("result shown with nothing pending");

  a_second_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rwcp_pkg::S_EMIT1 |-> sts_i.ev_cnt == 2'd2)
    else $error("second result shown with one pending");

endmodule
`default_nettype wire

// ===== rtl/riff_wave_chunk_parser_unit.sv =====
// riff_wave_chunk_parser_unit: top level of the RIFF WAVE chunk parser.
// Depends on rwcp_pkg, rwcp_ctrl, rwcp_datapath (and rwcp_divider below it).
//
//  channel | signals                          | word
//  --------+----------------------------------+-------------------------
//  in      | in_valid_i, in_stall_o, in_word_i | one file byte + last flag
//  out     | out_valid_o, out_stall_i, out_word_o | one parse event
//
// One byte at a time: accept, dispatch, then emit each pending event in turn,
// holding while out_stall_i is high. The input stalls until all are emitted.
// A data chunk header adds two divides (load plus 32 quotient bits each)
// in the shared divider plus one total update before its events are shown.
// Reset is asynchronous, active low; parse state returns to the RIFF header.
// Bytes after done or error are accepted and dropped.
`default_nettype none
module riff_wave_chunk_parser_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rwcp_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rwcp_pkg::out_word_t      out_word_o
);

  rwcp_pkg::cmd_t cmd;
  rwcp_pkg::sts_t sts;

  // sequencer: handshakes and step order
  rwcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // parse state, divider and result word; word is held while stalled
  rwcp_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

// ===== sim/tb_riff_wave_chunk_parser_unit.sv =====
// tb_riff_wave_chunk_parser_unit: self-checking testbench for the RIFF WAVE chunk parser.
// Depends on rwcp_pkg and riff_wave_chunk_parser_unit. It predicts each parse event,
// compares it field by field, idles the input and stalls the output at random.
`timescale 1ns / 100ps
`default_nettype none
module tb_riff_wave_chunk_parser_unit;

  localparam int STALL_LIMIT = 20000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  rwcp_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rwcp_pkg::out_word_t out_word_o;

  riff_wave_chunk_parser_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // Parser shadow state: walks the same phases as the block.
  // ---------------------------------------------------------------
  rwcp_pkg::phase_e pr_phase;
  logic [31:0] pr_count;
  logic [32:0] pr_left;      // bytes left of the declared size
  logic [31:0] pr_pos;
  logic [31:0] pr_tag;
  logic [31:0] pr_len;
  logic        pr_fmt_seen;
  logic [15:0] pr_fmt_tag;
  logic [15:0] pr_chans;
  logic [31:0] pr_rate;
  logic [15:0] pr_bits;
  logic [31:0] pr_sum;

  rwcp_pkg::out_word_t event_q[$];     // parse events still owed by the block
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        bytes_sent = 0;
  int        burst_left = 0;
  logic      hold_req = 1'b0;

  function automatic logic [13:0] pr_sample_bytes();
    logic [16:0] r;
    r = ({1'b0, pr_bits} + 17'd7) >> 3;
    return r[13:0];
  endfunction

  function automatic void post_event(logic [1:0] kind, logic [3:0] code,
                                     logic [31:0] offs, logic [31:0] total);
    rwcp_pkg::out_word_t e;
    logic      good;
    good = (kind != rwcp_pkg::EV_ERROR);
    e.event_kind    = kind;
    e.error_code    = code;
    e.rate_sps      = good ? pr_rate : '0;
    e.channel_count = good ? pr_chans : '0;
    e.sample_bytes  = good ? pr_sample_bytes() : '0;
    e.chunk_offset  = offs;
    e.sample_total  = total;
    e.run_last      = 1'b0;
    event_q.insert(event_q.size(), e);
  endfunction

  function automatic void raise_error(logic [3:0] code);
    pr_phase = rwcp_pkg::PH_ERROR;
    post_event(rwcp_pkg::EV_ERROR, code, '0, '0);
  endfunction

  function automatic void finish_parse();
    pr_phase = rwcp_pkg::PH_DONE;
    post_event(rwcp_pkg::EV_DONE, rwcp_pkg::ERR_NONE, '0, pr_sum);
  endfunction

  function automatic void parser_reset();
    pr_phase = rwcp_pkg::PH_HEADER; pr_count = '0; pr_left = '0; pr_pos = '0;
    pr_tag = '0; pr_len = '0; pr_fmt_seen = 1'b0; pr_fmt_tag = '0;
    pr_chans = '0; pr_rate = '0; pr_bits = '0; pr_sum = '0;
  endfunction

  // Advance the shadow parser by one accepted byte.
  function automatic void parse_byte(rwcp_pkg::in_word_t w);
    int          n_prior;
    logic [31:0] idx;
    logic [7:0]  b;
    logic [32:0] padded;
    logic [31:0] cnt;
    logic [13:0] sb;
    n_prior = event_q.size();
    if (pr_phase == rwcp_pkg::PH_DONE || pr_phase == rwcp_pkg::PH_ERROR) return;
    b = w.data_byte;
    pr_pos = pr_pos + 32'd1;
    idx = pr_count;
    pr_count = idx + 32'd1;
    case (pr_phase)
      rwcp_pkg::PH_HEADER: begin
        pr_tag = {b, pr_tag[31:8]};
        if (idx >= 4 && idx <= 7) pr_len[8*(idx-4) +: 8] = b;
        if (idx == 3 && pr_tag != rwcp_pkg::TAG_RIFF) begin
          raise_error(rwcp_pkg::ERR_NOT_RIFF);
        end else if (idx == 7) begin
          pr_left = (pr_len < 4) ? '0 : {1'b0, pr_len} - 33'd4;
        end else if (idx == 11) begin
          if (pr_tag != rwcp_pkg::TAG_WAVE) raise_error(rwcp_pkg::ERR_NOT_WAVE);
          else if (pr_left == 0) finish_parse();
          else begin
            pr_phase = rwcp_pkg::PH_CHUNK;
            pr_count = '0;
          end
        end
      end
      rwcp_pkg::PH_CHUNK: begin
        if (idx == 0) pr_len = '0;
        if (idx < 4) pr_tag = {b, pr_tag[31:8]};
        else pr_len[8*((idx-4)&3) +: 8] = b;
        pr_left = pr_left - 33'd1;
        if (idx == 7) begin
          padded = ({1'b0, pr_len} + 33'd1) & ~33'd1;
          pr_count = '0;
          pr_phase = (padded == 0) ? rwcp_pkg::PH_CHUNK : rwcp_pkg::PH_SKIP;
          if (pr_tag == rwcp_pkg::TAG_FMT) begin
            if (pr_fmt_seen) raise_error(rwcp_pkg::ERR_SECOND);
            else if (pr_len < 16) raise_error(rwcp_pkg::ERR_SHORT_FMT);
            else begin
              pr_fmt_seen = 1'b1;
              pr_phase = rwcp_pkg::PH_FMT;
            end
          end else if (pr_tag == rwcp_pkg::TAG_DATA) begin
            if (!pr_fmt_seen) raise_error(rwcp_pkg::ERR_NO_FMT);
            else begin
              sb = pr_sample_bytes();
              cnt = '0;
              if (sb != 0 && pr_chans != 0)
                cnt = pr_len / {18'd0, sb} / {16'd0, pr_chans};
              pr_sum = (pr_sum > 32'hFFFF_FFFF - cnt) ? 32'hFFFF_FFFF : pr_sum + cnt;
              post_event(rwcp_pkg::EV_DATA, rwcp_pkg::ERR_NONE, pr_pos, cnt);
            end
          end
          if (pr_phase != rwcp_pkg::PH_ERROR && pr_left == 0) finish_parse();
        end else if (pr_left == 0) begin
          finish_parse();
        end
      end
      default: begin  // fmt body or skipped body
        padded = ({1'b0, pr_len} + 33'd1) & ~33'd1;
        if (pr_phase == rwcp_pkg::PH_FMT && idx < 16) begin
          if (idx < 2) pr_fmt_tag[8*idx +: 8] = b;
          else if (idx < 4) pr_chans[8*(idx-2) +: 8] = b;
          else if (idx < 8) pr_rate[8*(idx-4) +: 8] = b;
          else if (idx >= 14) pr_bits[8*(idx-14) +: 8] = b;
        end
        pr_left = pr_left - 33'd1;
        if (pr_phase == rwcp_pkg::PH_FMT && idx == 15) begin
          if (pr_fmt_tag != 16'd1) raise_error(rwcp_pkg::ERR_NOT_PCM);
          else if (pr_chans == 0 || pr_bits == 0) raise_error(rwcp_pkg::ERR_ZERO);
          else post_event(rwcp_pkg::EV_FORMAT, rwcp_pkg::ERR_NONE, '0, '0);
        end
        if (pr_phase != rwcp_pkg::PH_ERROR) begin
          if (pr_left == 0) finish_parse();
          else if ({1'b0, idx} + 33'd1 == padded) begin
            pr_phase = rwcp_pkg::PH_CHUNK;
            pr_count = '0;
          end
        end
      end
    endcase
    if (w.last_byte && pr_phase != rwcp_pkg::PH_DONE && pr_phase != rwcp_pkg::PH_ERROR)
      raise_error(rwcp_pkg::ERR_TRUNC);
    if (event_q.size() > n_prior) event_q[event_q.size()-1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // Sender: bursts of words with random gaps; the predictor advances
  // on the edge that accepts each word.
  // ---------------------------------------------------------------
  task automatic send_word(logic [7:0] b, logic lastb);
    int gap;
    rwcp_pkg::in_word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    w.data_byte = b;
    w.last_byte = lastb;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(w);
    bytes_sent++;
  endtask

  task automatic send_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) send_word(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_body(int len);
    for (int i = 0; i < len; i++) send_word(8'($urandom), 1'b0);
    if (len % 2) send_word(8'($urandom), 1'b0);  // pad byte
  endtask

  function automatic bit parse_over();
    return pr_phase == rwcp_pkg::PH_DONE || pr_phase == rwcp_pkg::PH_ERROR;
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_riff_header(logic [31:0] declared);
    send_le32(rwcp_pkg::TAG_RIFF);
    send_le32(declared);
    send_le32(rwcp_pkg::TAG_WAVE);
  endtask

  // PCM fmt chunk; bodies longer than 16 bytes exercise the skipped tail.
  task automatic test_format_chunk(logic [15:0] chans, logic [31:0] rate,
                                   logic [15:0] bits, int len);
    send_le32(rwcp_pkg::TAG_FMT);
    send_le32(len);
    send_word(8'd1, 1'b0); send_word(8'd0, 1'b0);
    send_word(chans[7:0], 1'b0); send_word(chans[15:8], 1'b0);
    send_le32(rate);
    send_le32($urandom);                        // byte rate, unused
    send_word(8'($urandom), 1'b0); send_word(8'($urandom), 1'b0);  // block align
    send_word(bits[7:0], 1'b0); send_word(bits[15:8], 1'b0);
    send_body(len - 16);
  endtask

  task automatic test_data_chunk(int len);
    send_le32(rwcp_pkg::TAG_DATA);
    send_le32(len);
    send_body(len);
  endtask

  task automatic test_other_chunk(int len);
    send_le32($urandom);
    send_le32(len);
    send_body(len);
  endtask

  task automatic test_chunk_walk(int quota);
    while (!parse_over() && bytes_sent < quota) begin
      case ($urandom_range(0, 9))
        0, 1:    test_other_chunk($urandom_range(0, 9));
        2:       test_data_chunk(0);
        9:       test_data_chunk($urandom_range(20, 40));
        default: test_data_chunk($urandom_range(1, 12));
      endcase
    end
  endtask

  // Receiver holds off while data headers keep arriving, so the block backs up.
  task automatic test_backpressure();
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    for (int i = 0; i < 4 && !parse_over(); i++) test_data_chunk($urandom_range(0, 3));
  endtask

  // The run ends one of three ways: input cut short, a second fmt, or the declared end.
  task automatic test_ending(int mode);
    if (mode == 0) begin
      for (int i = 0; i < 5 && !parse_over(); i++) send_word(8'($urandom), 1'b0);
      if (!parse_over()) send_word(8'($urandom), 1'b1);
    end else if (mode == 1) begin
      if (!parse_over()) test_format_chunk(16'd2, 32'd48000, 16'd16, 16);
    end else begin
      while (!parse_over()) test_other_chunk($urandom_range(0, 7));
    end
    // late bytes are dropped by the block
    for (int i = 0; i < 6; i++) send_word(8'($urandom), i == 5);
    in_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------
  // Receiver: stall pattern of its own plus the long hold-off.
  // ---------------------------------------------------------------
  int hold_cnt = 0;
  int pat_mode = 0;
  int pat_left = 0;
  int pat_phase = 0;

  always @(posedge clk_i) begin
    logic stall_next;
    if (hold_req) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    if (pat_left == 0) begin
      pat_left <= $urandom_range(20, 200);
      pat_mode <= $urandom_range(0, 3);
    end else begin
      pat_left <= pat_left - 1;
    end
    pat_phase <= pat_phase + 1;
    case (pat_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(0, 3) == 0);
      2:       stall_next = (pat_phase % 5) < 2;
      default: stall_next = ($urandom_range(0, 1) == 0);
    endcase
    if (hold_req || hold_cnt > 1) stall_next = 1'b1;
    out_stall_i <= stall_next;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Checker: one event word per accepting edge, against the oldest expectation.
  always @(posedge clk_i) begin
    rwcp_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (event_q.size() == 0) begin
        report_mismatch("unexpected word", out_word_o.event_kind, '0);
      end else begin
        want = event_q.pop_front();
        if (out_word_o.event_kind != want.event_kind)
          report_mismatch("event_kind", out_word_o.event_kind, want.event_kind);
        if (out_word_o.error_code != want.error_code)
          report_mismatch("error_code", out_word_o.error_code, want.error_code);
        if (out_word_o.rate_sps != want.rate_sps)
          report_mismatch("rate_sps", out_word_o.rate_sps, want.rate_sps);
        if (out_word_o.channel_count != want.channel_count)
          report_mismatch("channel_count", out_word_o.channel_count, want.channel_count);
        if (out_word_o.sample_bytes != want.sample_bytes)
          report_mismatch("sample_bytes", out_word_o.sample_bytes, want.sample_bytes);
        if (out_word_o.chunk_offset != want.chunk_offset)
          report_mismatch("chunk_offset", out_word_o.chunk_offset, want.chunk_offset);
        if (out_word_o.sample_total != want.sample_total)
          report_mismatch("sample_total", out_word_o.sample_total, want.sample_total);
        if (out_word_o.run_last != want.run_last)
          report_mismatch("run_last", out_word_o.run_last, want.run_last);
      end
    end
  end

  // Watchdog: counts edges where no word moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("tb_riff_wave_chunk_parser_unit: FAIL");
      $finish;
    end
  end

  initial begin
    int ending;
    int rate_pick;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    parser_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ending = $urandom_range(0, 2);
    test_riff_header(ending == 2 ? $urandom_range(450, 550) : 32'hFFFF_FFFF);
    // a skipped chunk before fmt, odd length to force a pad byte
    test_other_chunk(3);
    rate_pick = $urandom_range(0, 2);
    rate  = (rate_pick == 0) ? 32'hFFFF_FFFF : (rate_pick == 1) ? 32'd1 : $urandom;
    chans = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 3));
    bits  = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 33));
    test_format_chunk(chans, rate, bits, $urandom_range(0, 1) ? 16 : 19);
    test_data_chunk(0);
    test_data_chunk(1);
    test_chunk_walk(250);
    test_backpressure();
    test_chunk_walk(500);
    test_ending(ending);

    while (event_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && event_q.size() == 0) begin
      $display("tb_riff_wave_chunk_parser_unit: PASS");
    end else begin
      $display("tb_riff_wave_chunk_parser_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
